### hdl/tcst_pkg.sv
// shared types, codes and defaults of the call-stack tracker
`timescale 1ns / 1ps

package tcst_pkg;

    localparam int DEF_STACK_DEPTH  = 32;
    localparam int DEF_FUNC_ID_BITS = 16;

    // event codes carried in event_kind
    typedef enum logic [1:0] {
        EV_OPEN  = 2'd0,
        EV_CLOSE = 2'd1,
        EV_WARN  = 2'd2,
        EV_OVF   = 2'd3
    } t_kind;

    // one trace record as latched by the datapath
    typedef struct packed {
        logic        known;
        logic [15:0] function_id;
        logic [7:0]  binary_id;
        logic [63:0] cycle;
        logic [63:0] instruction_address;
        logic        callsite;
        logic        entry;
        logic        asm_seq;
    } t_rec;

    // one event word
    typedef struct packed {
        t_kind       event_kind;
        logic [15:0] event_function;
        logic [7:0]  event_binary;
        logic [5:0]  event_depth;
        logic [63:0] start_stamp;
        logic [63:0] end_stamp;
        logic        catch_all;
        logic [63:0] warn_address;
        logic        last;
    } t_event;

    // controller to datapath
    typedef struct packed {
        logic  rec_load;  // latch the accepted record
        logic  pop;       // drop the top frame
        logic  touch;     // set end cycle of the (new) top frame
        logic  push;      // store a frame for the record
        logic  mark;      // remember the depth where unwinding starts
        logic  ev_load;   // stage an event word
        t_kind ev_kind;
        logic  flush;     // release the staged word as the last of the record
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic full;
        logic top_misc;
        logic top_asm;
        logic top_match;
        logic rec_known;
        logic rec_callsite;
        logic rec_entry;
        logic rec_asm;
        logic pend_v;
        logic ev_room;
        logic flush_room;
    } t_sts;

endpackage

### hdl/tcst_rec_if.sv
// trace record channel
`timescale 1ns / 1ps

interface tcst_rec_if;
    logic        valid;
    logic        ready;
    logic        known;
    logic [15:0] function_id;
    logic [7:0]  binary_id;
    logic [63:0] cycle;
    logic [63:0] instruction_address;
    logic        callsite;
    logic        entry;
    logic        asm_seq;

    modport source (
        output valid, known, function_id, binary_id, cycle, instruction_address,
               callsite, entry, asm_seq,
        input  ready
    );
    modport sink (
        input  valid, known, function_id, binary_id, cycle, instruction_address,
               callsite, entry, asm_seq,
        output ready
    );
endinterface

### hdl/tcst_evt_if.sv
// frame event channel
`timescale 1ns / 1ps

interface tcst_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [15:0] event_function;
    logic [7:0]  event_binary;
    logic [5:0]  event_depth;
    logic [63:0] start_stamp;
    logic [63:0] end_stamp;
    logic        catch_all;
    logic [63:0] warn_address;
    logic        last;

    modport source (
        output valid, event_kind, event_function, event_binary, event_depth,
               start_stamp, end_stamp, catch_all, warn_address, last,
        input  ready
    );
    modport sink (
        input  valid, event_kind, event_function, event_binary, event_depth,
               start_stamp, end_stamp, catch_all, warn_address, last,
        output ready
    );
endinterface

### hdl/trace_call_stack_tracker.sv
// top level of the call-stack tracker
`timescale 1ns / 1ps

// usage
// - i_rec carries one retired-instruction trace record per word; o_evt carries
//   frame open, frame close, stack-emptied warning and overflow event words
// - a record that only moves the top frame's end cycle produces no word; a
//   record that opens a frame produces an open word, preceded by a close word
//   when the catch-all frame has to be closed first
// - an unwind closes one frame per pass through S_UNWIND and S_FETCH (the
//   frame memory has a registered read port, so each pop waits in S_FETCH for
//   the new top), besides accept, decide, open or warn and last-word release
// - i_rec.ready is high only while no record is in progress
// - the final word of a record has last set; one word is held back in a
//   staging register until the next word or the end of the record decides it
// - o_evt is a registered output; while the receiver stalls the block keeps
//   working until it needs to hand over a further word, then waits
// - after reset the stack is empty and no word is pending; the frame memory
//   needs no clearing pass since only entries below the frame count are read
module trace_call_stack_tracker #(
    parameter int STACK_DEPTH  = tcst_pkg::DEF_STACK_DEPTH,
    parameter int FUNC_ID_BITS = tcst_pkg::DEF_FUNC_ID_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcst_rec_if.sink   i_rec,
    tcst_evt_if.source o_evt
);

    tcst_pkg::t_rec   rec;
    tcst_pkg::t_cmd   cmd;
    tcst_pkg::t_sts   sts;
    tcst_pkg::t_event evt;
    logic             evt_valid;
    logic             in_ready;

    // pack the incoming word for the datapath latch
    assign rec.known               = i_rec.known;
    assign rec.function_id         = i_rec.function_id;
    assign rec.binary_id           = i_rec.binary_id;
    assign rec.cycle               = i_rec.cycle;
    assign rec.instruction_address = i_rec.instruction_address;
    assign rec.callsite            = i_rec.callsite;
    assign rec.entry               = i_rec.entry;
    assign rec.asm_seq             = i_rec.asm_seq;
    assign i_rec.ready             = in_ready;

    // sequencer: one record at a time
    tcst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rec.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // frame stack and event staging
    tcst_datapath #(
        .STACK_DEPTH  (STACK_DEPTH),
        .FUNC_ID_BITS (FUNC_ID_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (rec),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_evt       (evt),
        .o_evt_valid (evt_valid),
        .i_evt_ready (o_evt.ready)
    );

    // unpack the output word onto the event channel
    assign o_evt.valid          = evt_valid;
    assign o_evt.event_kind     = evt.event_kind;
    assign o_evt.event_function = evt.event_function;
    assign o_evt.event_binary   = evt.event_binary;
    assign o_evt.event_depth    = evt.event_depth;
    assign o_evt.start_stamp    = evt.start_stamp;
    assign o_evt.end_stamp      = evt.end_stamp;
    assign o_evt.catch_all      = evt.catch_all;
    assign o_evt.warn_address   = evt.warn_address;
    assign o_evt.last           = evt.last;

endmodule

### hdl/tcst_datapath.sv
// frame stack memory, record latch and event staging of the call-stack tracker
`timescale 1ns / 1ps

module tcst_datapath #(
    parameter int STACK_DEPTH  = tcst_pkg::DEF_STACK_DEPTH,
    parameter int FUNC_ID_BITS = tcst_pkg::DEF_FUNC_ID_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tcst_pkg::t_rec  i_rec,
    input  tcst_pkg::t_cmd  i_cmd,
    output tcst_pkg::t_sts  o_sts,
    output tcst_pkg::t_event o_evt,
    output logic            o_evt_valid,
    input  logic            i_evt_ready
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int FW = FUNC_ID_BITS;

    tcst_pkg::t_rec r_rec;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_lvl;

    logic [FW-1:0]  mem_func  [STACK_DEPTH];
    logic [7:0]     mem_bin   [STACK_DEPTH];
    logic [63:0]    mem_start [STACK_DEPTH];
    logic [63:0]    mem_end   [STACK_DEPTH];
    logic           mem_misc  [STACK_DEPTH];
    logic           mem_asm   [STACK_DEPTH];

    logic [FW-1:0]  r_top_func;
    logic [7:0]     r_top_bin;
    logic [63:0]    r_top_start;
    logic [63:0]    r_top_end;
    logic           r_top_misc;
    logic           r_top_asm;

    tcst_pkg::t_event r_pend, r_out, n_out, ev_new;
    logic             r_pend_v, r_out_v, n_out_v;

    logic [31:0]    new_func_w, top_func_w;
    logic [FW-1:0]  rec_func, new_func;
    logic [CW-1:0]  cnt_m1, cnt_m2;
    logic [AW-1:0]  top_addr, push_addr, end_addr;
    logic           touch_ok, end_we;

    // function ids are kept at FW bits, reported at the 16-bit port width
    assign rec_func   = FW'(r_rec.function_id);
    assign new_func   = r_rec.known ? rec_func : '0;
    assign new_func_w = 32'(new_func);
    assign top_func_w = 32'(r_top_func);

    assign cnt_m1    = r_count - CW'(1);
    assign cnt_m2    = r_count - CW'(2);
    assign top_addr  = cnt_m1[AW-1:0];
    assign push_addr = r_count[AW-1:0];

    // touch hits the frame that is on top after this cycle's pop, if any
    assign touch_ok = i_cmd.touch &&
                      (i_cmd.pop ? (r_count > CW'(1)) : (r_count != '0));
    assign end_we   = i_cmd.push || touch_ok;
    assign end_addr = i_cmd.push ? push_addr :
                      (i_cmd.pop ? cnt_m2[AW-1:0] : top_addr);

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = cnt_m1;
        end
    end

    // frame memories, read port follows the top of stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem_func[push_addr]  <= new_func;
            mem_bin[push_addr]   <= r_rec.binary_id;
            mem_start[push_addr] <= r_rec.cycle;
            mem_misc[push_addr]  <= !r_rec.known;
            mem_asm[push_addr]   <= r_rec.known && r_rec.asm_seq;
        end
        if (end_we) begin
            mem_end[end_addr] <= r_rec.cycle;
        end
        r_top_func  <= mem_func[top_addr];
        r_top_bin   <= mem_bin[top_addr];
        r_top_start <= mem_start[top_addr];
        r_top_end   <= mem_end[top_addr];
        r_top_misc  <= mem_misc[top_addr];
        r_top_asm   <= mem_asm[top_addr];
    end

    // event word for the requested kind
    always_comb begin
        ev_new                = '0;
        ev_new.event_kind     = i_cmd.ev_kind;
        ev_new.event_function = new_func_w[15:0];
        ev_new.event_binary   = r_rec.binary_id;
        ev_new.start_stamp    = r_rec.cycle;
        ev_new.end_stamp      = r_rec.cycle;
        ev_new.catch_all      = !r_rec.known;
        case (i_cmd.ev_kind)
            tcst_pkg::EV_CLOSE: begin
                ev_new.event_function = top_func_w[15:0];
                ev_new.event_binary   = r_top_bin;
                ev_new.event_depth    = 6'(r_count);
                ev_new.start_stamp    = r_top_start;
                ev_new.end_stamp      = r_top_end;
                ev_new.catch_all      = r_top_misc;
            end
            tcst_pkg::EV_OPEN: begin
                ev_new.event_depth = 6'(r_count) + 6'd1;
            end
            tcst_pkg::EV_WARN: begin
                ev_new.event_depth    = 6'(r_lvl);
                ev_new.catch_all      = 1'b0;
                ev_new.warn_address   = r_rec.instruction_address;
            end
            tcst_pkg::EV_OVF: begin
                ev_new.event_depth = 6'(STACK_DEPTH);
            end
            default: begin
                ev_new.event_depth = '0;
            end
        endcase
    end

    // staged word moves out when the next one arrives or the record ends
    always_comb begin
        n_out_v = r_out_v && !i_evt_ready;
        n_out   = r_out;
        if ((i_cmd.ev_load && r_pend_v) || i_cmd.flush) begin
            n_out_v   = 1'b1;
            n_out     = r_pend;
            n_out.last = i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rec_load) begin
            r_rec <= i_rec;
        end
        if (i_cmd.mark) begin
            r_lvl <= r_count;
        end
        if (i_cmd.ev_load) begin
            r_pend <= ev_new;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_out_v  <= n_out_v;
            if (i_cmd.ev_load) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    assign o_sts.count_zero   = (r_count == '0);
    assign o_sts.count_one    = (r_count == CW'(1));
    assign o_sts.full         = (r_count >= CW'(STACK_DEPTH));
    assign o_sts.top_misc     = r_top_misc;
    assign o_sts.top_asm      = r_top_asm;
    assign o_sts.top_match    = (r_top_func == rec_func);
    assign o_sts.rec_known    = r_rec.known;
    assign o_sts.rec_callsite = r_rec.callsite;
    assign o_sts.rec_entry    = r_rec.entry;
    assign o_sts.rec_asm      = r_rec.asm_seq;
    assign o_sts.pend_v       = r_pend_v;
    assign o_sts.ev_room      = !r_pend_v || !r_out_v || i_evt_ready;
    assign o_sts.flush_room   = !r_out_v || i_evt_ready;

    assign o_evt       = r_out;
    assign o_evt_valid = r_out_v;

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (r_count < CW'(STACK_DEPTH)))
        else $error("push into a full frame stack");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_count != '0))
        else $error("pop from an empty frame stack");

    a_no_word_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ev_load && r_pend_v) || i_cmd.flush |-> (!r_out_v || i_evt_ready))
        else $error("staged word moved over an unread output word");

    a_flush_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |-> (r_pend_v && !i_cmd.ev_load))
        else $error("flush without a staged word");

endmodule

### hdl/tcst_ctrl.sv
// record sequencing state machine of the call-stack tracker
`timescale 1ns / 1ps

module tcst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tcst_pkg::t_sts i_sts,
    output tcst_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DECIDE  = 7'b0000010,
        S_REFETCH = 7'b0000100,
        S_UNWIND  = 7'b0001000,
        S_FETCH   = 7'b0010000,
        S_PUSH    = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

    t_state r_state, n_state, s_end;
    logic   r_all, n_all;

    // a record that staged any word ends by releasing it with last set
    assign s_end = i_sts.pend_v ? S_DONE : S_IDLE;

    always_comb begin
        n_state    = r_state;
        n_all      = r_all;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.rec_load = 1'b1;
                    n_state        = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_sts.rec_known) begin
                    if (i_sts.count_one && i_sts.top_misc) begin
                        o_cmd.touch = 1'b1;
                        n_state     = s_end;
                    end else if (i_sts.count_zero) begin
                        n_state = S_PUSH;
                    end else begin
                        n_all   = 1'b1;
                        n_state = S_UNWIND;
                    end
                end else if (!i_sts.count_zero && i_sts.top_misc) begin
                    if (i_sts.ev_room) begin
                        o_cmd.ev_load = 1'b1;
                        o_cmd.ev_kind = tcst_pkg::EV_CLOSE;
                        o_cmd.pop     = 1'b1;
                        n_state       = S_REFETCH;
                    end
                end else if (!i_sts.count_zero && i_sts.top_match) begin
                    o_cmd.touch = 1'b1;
                    n_state     = s_end;
                end else if (!i_sts.count_zero && i_sts.rec_asm && i_sts.top_asm) begin
                    if (i_sts.ev_room) begin
                        o_cmd.ev_load = 1'b1;
                        o_cmd.ev_kind = tcst_pkg::EV_CLOSE;
                        o_cmd.pop     = 1'b1;
                        n_state       = S_PUSH;
                    end
                end else if (!i_sts.count_zero &&
                             (i_sts.rec_callsite || !i_sts.rec_entry)) begin
                    o_cmd.mark = 1'b1;
                    n_all      = 1'b0;
                    n_state    = S_UNWIND;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_REFETCH: begin
                n_state = S_DECIDE;
            end
            S_UNWIND: begin
                if (i_sts.count_zero) begin
                    if (r_all) begin
                        n_state = S_PUSH;
                    end else if (i_sts.ev_room) begin
                        o_cmd.ev_load = 1'b1;
                        o_cmd.ev_kind = tcst_pkg::EV_WARN;
                        n_state       = S_DONE;
                    end
                end else if (r_all || i_sts.top_misc || !i_sts.top_match) begin
                    if (i_sts.ev_room) begin
                        o_cmd.ev_load = 1'b1;
                        o_cmd.ev_kind = tcst_pkg::EV_CLOSE;
                        o_cmd.pop     = 1'b1;
                        o_cmd.touch   = 1'b1;
                        n_state       = S_FETCH;
                    end
                end else begin
                    n_state = s_end;
                end
            end
            S_FETCH: begin
                n_state = S_UNWIND;
            end
            S_PUSH: begin
                if (i_sts.ev_room) begin
                    o_cmd.ev_load = 1'b1;
                    if (i_sts.full) begin
                        o_cmd.ev_kind = tcst_pkg::EV_OVF;
                    end else begin
                        o_cmd.ev_kind = tcst_pkg::EV_OPEN;
                        o_cmd.push    = 1'b1;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.pend_v) begin
                    n_state = S_IDLE;
                end else if (i_sts.flush_room) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_all   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_all   <= n_all;
        end
    end

endmodule
